[sv/lfo_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfo_pkg: shared types and constants of the LFO wave generator
// Register indexes, sequencer states, divider handshake and Horner reciprocals.
// ----------------------------------------------------------------------------
package lfo_pkg;

  // Defaults of the top-level parameters
  localparam int MaxPeriodDef = 4096;
  localparam int LevelBitsDef = 16;

  // Configuration port
  localparam int PerW   = 13;  // period_length register width
  localparam int CfgW   = 13;  // widest register
  localparam int CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] RegWaveform = 1'd0;
  localparam logic [CfgIdxW-1:0] RegPeriod   = 1'd1;

  // Reset values of the registers
  localparam logic [PerW-1:0] PeriodRst = 13'd256;

  // Shared divider
  localparam int DivW  = 48;
  localparam int DivCntW = $clog2(DivW + 1);

  // Fixed-point cosine, Q2.30
  localparam logic [31:0] TwoPiLo = 32'h921F_B544;  // low word of 2*pi*2^30
  localparam int HornerSteps = 9;
  localparam int HornerCntW = 4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_TDIV,
    ST_XDIV,
    ST_MA,
    ST_MB,
    ST_MC,
    ST_HM,
    ST_HD,
    ST_HW,
    ST_FIN,
    ST_DONE
  } lfo_state_e;

  typedef struct packed {
    logic             start;
    logic [DivW-1:0]  num;
    logic [PerW-1:0]  den;
  } lfo_div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DivW-1:0]  quot;
  } lfo_div_rsp_t;

  // Reciprocal of the divisor n*(n-1) of Horner step k (n = 2k), rounded up.
  // With d <= 2^l and shift 32 + l, (p * recip) >> shift equals floor(p / d)
  // for every p below 2^32.
  function automatic logic [32:0] horner_recip(input logic [HornerCntW-1:0] k);
    logic [32:0] r;
    case (k)
      4'd9:    r = 33'(((66'd1 << 41) + 66'd305) / 66'd306);
      4'd8:    r = 33'(((66'd1 << 40) + 66'd239) / 66'd240);
      4'd7:    r = 33'(((66'd1 << 40) + 66'd181) / 66'd182);
      4'd6:    r = 33'(((66'd1 << 40) + 66'd131) / 66'd132);
      4'd5:    r = 33'(((66'd1 << 39) + 66'd89) / 66'd90);
      4'd4:    r = 33'(((66'd1 << 38) + 66'd55) / 66'd56);
      4'd3:    r = 33'(((66'd1 << 37) + 66'd29) / 66'd30);
      4'd2:    r = 33'(((66'd1 << 36) + 66'd11) / 66'd12);
      4'd1:    r = 33'(((66'd1 << 33) + 66'd1) / 66'd2);
      default: r = 33'd0;
    endcase
    return r;
  endfunction

  // Right shift that goes with horner_recip
  function automatic logic [5:0] horner_shift(input logic [HornerCntW-1:0] k);
    logic [5:0] s;
    case (k)
      4'd9:    s = 6'd41;
      4'd8:    s = 6'd40;
      4'd7:    s = 6'd40;
      4'd6:    s = 6'd40;
      4'd5:    s = 6'd39;
      4'd4:    s = 6'd38;
      4'd3:    s = 6'd37;
      4'd2:    s = 6'd36;
      4'd1:    s = 6'd33;
      default: s = 6'd33;
    endcase
    return s;
  endfunction

endpackage

[sv/lfo_wave_generator.sv]
`timescale 1ns / 1ps
// Sequence: a triangle tick runs one division of a 48-bit numerator; a
//   raised-cosine tick runs the phase division, the angle, nine Horner steps
//   and the rounding. A triangle tick with a period below two skips the
//   division.
// Throughput: one tick at a time; the next tick is taken the cycle after the
//   result is loaded into the output register. Reset: waveform 0, period 256, phase 0.
// ----------------------------------------------------------------------------
// lfo_wave_generator: low-frequency oscillator, raised cosine or triangle
// Phase index kept in a one-entry memory, read, advanced and written back.
// ----------------------------------------------------------------------------
module lfo_wave_generator #(
  parameter int MAX_PERIOD = lfo_pkg::MaxPeriodDef,
  parameter int LEVEL_BITS = lfo_pkg::LevelBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lfo_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [lfo_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        restart_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [LEVEL_BITS-1:0]       level_o,
  output logic [$clog2(MAX_PERIOD)-1:0] position_o
);

  localparam int PosW = $clog2(MAX_PERIOD);
  localparam int FracW = LEVEL_BITS - 1;
  localparam int PerW = lfo_pkg::PerW;
  localparam int DivW = lfo_pkg::DivW;
  localparam logic [31:0] TwoPiLoW = lfo_pkg::TwoPiLo;

  lfo_pkg::lfo_state_e state_q, state_d;

  // Configuration registers
  logic            wave_q;
  logic [PerW-1:0] per_reg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q    <= 1'b0;
      per_reg_q <= lfo_pkg::PeriodRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lfo_pkg::RegWaveform: wave_q    <= cfg_data_i[0];
        lfo_pkg::RegPeriod:   per_reg_q <= cfg_data_i[PerW-1:0];
        default: ;
      endcase
    end
  end

  // Effective period, clamped to 1..MAX_PERIOD
  logic [PerW-1:0] per_eff;
  always_comb begin
    if (per_reg_q == '0) begin
      per_eff = PerW'(1);
    end else if (32'(per_reg_q) > MAX_PERIOD) begin
      per_eff = PerW'(MAX_PERIOD);
    end else begin
      per_eff = per_reg_q;
    end
  end

  // Phase memory, one entry, registered read
  logic [PosW-1:0] phase_mem [1];
  logic            mem_vld_q;
  logic [PosW-1:0] rd_q;
  logic            mem_rd, mem_wr;
  logic [PosW-1:0] wr_data;

  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      phase_mem[0] <= wr_data;
    end
    if (mem_rd) begin
      rd_q <= mem_vld_q ? phase_mem[0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_vld_q <= 1'b0;
    end else if (mem_wr) begin
      mem_vld_q <= 1'b1;
    end
  end

  // Tick context
  logic                   rst_flag_q;
  logic [PerW-1:0]        per_q;
  logic                   tri_q;
  logic [PosW-1:0]        idx_q;
  logic [1:0]             quad_q;
  logic [30:0]            uu_q;
  logic [62:0]            prod1_q;
  logic [30:0]            a_q;
  logic [31:0]            a2_q;
  logic [32:0]            prod2_q;
  logic [65:0]            hq_prod_q;
  logic [30:0]            t_q;
  logic [lfo_pkg::HornerCntW-1:0] k_q;
  logic [LEVEL_BITS-1:0]  lvl_q;
  logic                   out_valid_q;
  logic [LEVEL_BITS-1:0]  out_lvl_q;
  logic [PosW-1:0]        out_pos_q;

  lfo_pkg::lfo_div_req_t div_req;
  lfo_pkg::lfo_div_rsp_t div_rsp;

  lfo_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Current index: restart or a stale index past the period wraps to zero
  logic [PosW-1:0] idx_cur;
  logic [PosW-1:0] idx_next;
  logic [PerW-2:0] half;
  logic [PerW:0]   mirror, mdist;
  logic            in_acc, out_free;

  assign in_acc   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign half     = per_q[PerW-1:1];

  always_comb begin
    if (rst_flag_q || (32'(rd_q) >= 32'(per_q))) begin
      idx_cur = '0;
    end else begin
      idx_cur = rd_q;
    end
    if ((32'(idx_cur) + 32'd1) >= 32'(per_q)) begin
      idx_next = '0;
    end else begin
      idx_next = idx_cur + 1'b1;
    end
    // Triangle distance from the nearest end of the period
    mirror = {1'b0, half, 1'b0} - (PerW + 1)'(idx_cur);
    mdist  = ((PerW + 1)'(idx_cur) < mirror) ? (PerW + 1)'(idx_cur) : mirror;
    if (mdist > (PerW + 1)'(half)) begin
      mdist = (PerW + 1)'(half);
    end
  end

  // Next-state logic
  always_comb begin
    state_d = state_q;
    case (state_q)
      lfo_pkg::ST_IDLE: if (in_acc) state_d = lfo_pkg::ST_LOAD;
      lfo_pkg::ST_LOAD: begin
        if (!tri_q) state_d = lfo_pkg::ST_XDIV;
        else if (half == '0) state_d = lfo_pkg::ST_DONE;
        else state_d = lfo_pkg::ST_TDIV;
      end
      lfo_pkg::ST_TDIV: if (div_rsp.done) state_d = lfo_pkg::ST_DONE;
      lfo_pkg::ST_XDIV: if (div_rsp.done) state_d = lfo_pkg::ST_MA;
      lfo_pkg::ST_MA:   state_d = lfo_pkg::ST_MB;
      lfo_pkg::ST_MB:   state_d = lfo_pkg::ST_MC;
      lfo_pkg::ST_MC:   state_d = lfo_pkg::ST_HM;
      lfo_pkg::ST_HM:   state_d = lfo_pkg::ST_HD;
      lfo_pkg::ST_HD:   state_d = lfo_pkg::ST_HW;
      lfo_pkg::ST_HW: begin
        state_d = (k_q == lfo_pkg::HornerCntW'(1)) ? lfo_pkg::ST_FIN : lfo_pkg::ST_HM;
      end
      lfo_pkg::ST_FIN:  state_d = lfo_pkg::ST_DONE;
      lfo_pkg::ST_DONE: if (out_free) state_d = lfo_pkg::ST_IDLE;
      default:          state_d = lfo_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready_o    = 1'b0;
    mem_rd        = 1'b0;
    mem_wr        = 1'b0;
    wr_data       = idx_next;
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = per_q;
    case (state_q)
      lfo_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        mem_rd     = 1'b1;
      end
      lfo_pkg::ST_LOAD: begin
        mem_wr = 1'b1;
        if (tri_q) begin
          div_req.start = (half != '0);
          div_req.den   = PerW'(half);
          div_req.num   = (DivW'((PerW + 1)'(half) - mdist) << FracW)
                          + DivW'(half[PerW-2:1]);
        end else begin
          div_req.start = 1'b1;
          div_req.num   = (DivW'(idx_cur) << 32) + DivW'(half);
        end
      end
      default: ;
    endcase
  end

  // Datapath
  logic [31:0] x_word;
  logic [31:0] a_sum;
  logic [61:0] a_sq;
  logic [62:0] at_prod;
  logic [65:0] hq_quot;
  logic [30:0] term;
  logic [31:0] v_val;
  logic [32:0] v_rnd;

  always_comb begin
    x_word  = div_rsp.quot[31:0];
    a_sum   = 32'(uu_q) + 32'(prod1_q[62:32]);
    a_sq    = 62'(a_q) * 62'(a_q);
    at_prod = 63'(a2_q) * 63'(t_q);
    // Horner division by the step constant, then clamp to one
    hq_quot = hq_prod_q >> lfo_pkg::horner_shift(k_q);
    if (hq_quot > 66'h4000_0000) begin
      term = 31'h4000_0000;
    end else begin
      term = hq_quot[30:0];
    end
    if (quad_q == 2'd0 || quad_q == 2'd3) begin
      v_val = 32'h4000_0000 + 32'(t_q);
    end else begin
      v_val = 32'h4000_0000 - 32'(t_q);
    end
    v_rnd = 33'(v_val) + (33'd1 << (30 - FracW));
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      lfo_pkg::ST_IDLE: begin
        rst_flag_q <= restart_i;
        per_q      <= per_eff;
        tri_q      <= wave_q;
      end
      lfo_pkg::ST_LOAD: begin
        idx_q <= idx_cur;
        lvl_q <= LEVEL_BITS'(1) << FracW;
      end
      lfo_pkg::ST_TDIV: lvl_q <= div_rsp.quot[LEVEL_BITS-1:0];
      lfo_pkg::ST_XDIV: begin
        quad_q <= x_word[31:30];
        uu_q   <= x_word[30] ? (31'h4000_0000 - 31'(x_word[29:0])) : 31'(x_word[29:0]);
      end
      lfo_pkg::ST_MA: prod1_q <= 63'(uu_q) * 63'(TwoPiLoW);
      lfo_pkg::ST_MB: a_q <= a_sum[30:0];
      lfo_pkg::ST_MC: begin
        a2_q <= a_sq[61:30];
        t_q  <= 31'h4000_0000;
        k_q  <= lfo_pkg::HornerCntW'(lfo_pkg::HornerSteps);
      end
      lfo_pkg::ST_HM: prod2_q <= at_prod[62:30];
      lfo_pkg::ST_HD: hq_prod_q <= 66'(prod2_q) * 66'(lfo_pkg::horner_recip(k_q));
      lfo_pkg::ST_HW: begin
        t_q <= 31'h4000_0000 - term;
        k_q <= k_q - 1'b1;
      end
      lfo_pkg::ST_FIN: lvl_q <= LEVEL_BITS'(v_rnd >> (31 - FracW));
      default: ;
    endcase
  end

  // Sequencer state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lfo_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == lfo_pkg::ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == lfo_pkg::ST_DONE && out_free) begin
      out_lvl_q <= lvl_q;
      out_pos_q <= idx_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign level_o     = out_lvl_q;
  assign position_o  = out_pos_q;

  // Checks
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("input taken while a tick is in progress");

  a_div_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(position_o) < MAX_PERIOD))
    else $error("position beyond period");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (level_o <= (LEVEL_BITS'(1) << FracW)))
    else $error("level above full scale");

endmodule

[sv/lfo_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfo_div: restoring divider, one quotient bit per cycle
// Divides a DivW-bit numerator by a PerW-bit divisor.
// ----------------------------------------------------------------------------
module lfo_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lfo_pkg::lfo_div_req_t req_i,
  output lfo_pkg::lfo_div_rsp_t rsp_o
);

  logic [lfo_pkg::DivW-1:0]    num_q, num_d;
  logic [lfo_pkg::PerW-1:0]    den_q, den_d;
  logic [lfo_pkg::PerW:0]      rem_q, rem_d;
  logic [lfo_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [lfo_pkg::PerW:0]      rem_sh;
  logic                        fits;

  // Shift in the next numerator bit and try to subtract
  assign rem_sh = {rem_q[lfo_pkg::PerW-1:0], num_q[lfo_pkg::DivW-1]};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      num_d  = req_i.num;
      den_d  = req_i.den;
      rem_d  = '0;
      cnt_d  = lfo_pkg::DivCntW'(lfo_pkg::DivW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? rem_sh - {1'b0, den_q} : rem_sh;
      num_d = {num_q[lfo_pkg::DivW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == lfo_pkg::DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;

endmodule

[tb/lfo_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfo_checker: tick predictor and result scoreboard for the LFO
// Watches the config port and both channels, computes the level and position
// of every accepted tick and compares each output beat with the oldest one.
// ----------------------------------------------------------------------------
module lfo_checker #(
  parameter int MAX_PERIOD = 4096,
  parameter int LEVEL_BITS = 16,
  localparam int PosW      = $clog2(MAX_PERIOD)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lfo_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [lfo_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic                        restart_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [LEVEL_BITS-1:0]       level_i,
  input  logic [PosW-1:0]             position_i,
  output int                          fail_cnt_o,
  output int                          pending_o,
  output int                          checked_o
);

  localparam int FracBits = LEVEL_BITS - 1;
  localparam logic [63:0] Q30One  = 64'd1 << 30;
  localparam logic [63:0] TwoPiQ30 = 64'd6746518852;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] level;
    logic [PosW-1:0]       position;
  } tick_t;

  tick_t                    tick_q[$];
  logic                     shape_tri;
  logic [lfo_pkg::PerW-1:0] period_reg;
  logic [31:0]              phase_idx;

  // Cosine of a quarter-turn fraction in Q2.30, Horner form of the series
  function automatic logic [63:0] cos_quarter(input logic [63:0] u);
    logic [63:0] a, a2, t, term, n;
    a = (u * TwoPiQ30) >> 32;
    a2 = (a * a) >> 30;
    t = Q30One;
    for (int k = 9; k >= 1; k--) begin
      n = 64'(2 * k);
      term = ((a2 * t) >> 30) / (n * (n - 64'd1));
      if (term > Q30One) term = Q30One;
      t = Q30One - term;
    end
    return t;
  endfunction

  function automatic logic [63:0] cosine_level(input logic [63:0] i, input logic [63:0] p);
    logic [63:0] x, q, u, c, v;
    x = ((i << 32) + (p / 2)) / p;
    q = (x >> 30) & 64'd3;
    u = x & (Q30One - 64'd1);
    if (q == 0 || q == 2) c = cos_quarter(u);
    else c = cos_quarter(Q30One - u);
    if (q == 0 || q == 3) v = Q30One + c;
    else v = Q30One - ((c > Q30One) ? Q30One : c);
    return (v + (64'd1 << (30 - FracBits))) >> (31 - FracBits);
  endfunction

  function automatic logic [63:0] triangle_level(input logic [63:0] i, input logic [63:0] p);
    logic [63:0] h, m;
    h = p / 2;
    if (h == 0) return 64'd1 << FracBits;
    m = i;
    if (2 * h >= i && 2 * h - i < m) m = 2 * h - i;
    if (m > h) m = h;
    return (((h - m) << FracBits) + h / 2) / h;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_cnt_o++;
  endtask

  // Track config, predict accepted ticks, compare output beats
  always @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] per;
    logic [63:0] lvl;
    tick_t       want;
    if (!rst_ni) begin
      tick_q.delete();
      shape_tri  = 1'b0;
      period_reg = lfo_pkg::PeriodRst;
      phase_idx  = 0;
      fail_cnt_o = 0;
      checked_o  = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == lfo_pkg::RegWaveform) shape_tri = cfg_data_i[0];
        else if (cfg_idx_i == lfo_pkg::RegPeriod) period_reg = cfg_data_i[lfo_pkg::PerW-1:0];
      end
      if (in_valid_i && in_ready_i) begin
        per = period_reg;
        if (per < 1) per = 1;
        if (per > MAX_PERIOD) per = MAX_PERIOD;
        if (restart_i) phase_idx = 0;
        if (phase_idx >= per) phase_idx = 0;
        lvl = shape_tri ? triangle_level(phase_idx, per) : cosine_level(phase_idx, per);
        want.level    = lvl[LEVEL_BITS-1:0];
        want.position = phase_idx[PosW-1:0];
        tick_q.push_back(want);
        phase_idx = phase_idx + 1;
        if (phase_idx >= per) phase_idx = 0;
      end
      if (out_valid_i && out_ready_i) begin
        if (tick_q.size() == 0) begin
          report("output beat with no tick pending", level_i, 0);
        end else begin
          want = tick_q.pop_front();
          if (level_i !== want.level) report("level", level_i, want.level);
          if (position_i !== want.position) report("position", position_i, want.position);
          checked_o++;
        end
      end
    end
    pending_o = tick_q.size();
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the LFO wave generator
// Directed corner ticks, then random phases of waveform and period with
// random restarts and random idle gaps on both channels.
// ----------------------------------------------------------------------------
module tb;

  localparam int MaxPeriod = 4096;
  localparam int LevelBits = 16;
  localparam int PosW      = $clog2(MaxPeriod);
  localparam int CycleLimit = 2_000_000;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [lfo_pkg::CfgIdxW-1:0]   cfg_idx_i;
  logic [lfo_pkg::CfgW-1:0]      cfg_data_i;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic                          restart_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [LevelBits-1:0]          level_o;
  logic [PosW-1:0]               position_o;

  int  fail_cnt;
  int  pending;
  int  checked;
  int  cycles;
  int  phases;
  bit  no_gaps;

  lfo_wave_generator #(.MAX_PERIOD(MaxPeriod), .LEVEL_BITS(LevelBits)) u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .restart_i,
    .out_valid_o, .out_ready_i, .level_o, .position_o
  );

  lfo_checker #(.MAX_PERIOD(MaxPeriod), .LEVEL_BITS(LevelBits)) u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .restart_i,
    .out_valid_i(out_valid_o), .out_ready_i, .level_i(level_o), .position_i(position_o),
    .fail_cnt_o(fail_cnt), .pending_o(pending), .checked_o(checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("lfo_wave_generator: mismatch");
      $finish;
    end
  end

  // Output side: random stall before each beat
  initial begin
    int  gap;
    bit  seen;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do begin
        @(negedge clk_i);
        seen = out_valid_o;
        @(posedge clk_i);
      end while (!seen);
    end
  end

  // Send one tick beat after a random gap; returns on the accepting edge
  task automatic send_tick(input bit rst_pos);
    int gap;
    bit seen;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= rst_pos;
    do begin
      @(negedge clk_i);
      seen = in_ready_o;
      @(posedge clk_i);
    end while (!seen);
  endtask

  // Drop valid and hold until every predicted tick has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  // Drive one register write; the caller drops the enable
  task automatic write_reg(input logic [lfo_pkg::CfgIdxW-1:0] idx,
                           input logic [lfo_pkg::CfgW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  // One setting of both registers, then a run of ticks
  task automatic run_phase(input logic [lfo_pkg::CfgW-1:0] wave,
                           input logic [lfo_pkg::CfgW-1:0] per,
                           input int n, input int restart_pct);
    drain();
    write_reg(lfo_pkg::RegWaveform, wave);
    write_reg(lfo_pkg::RegPeriod, per);
    cfg_we_i <= 1'b0;
    phases++;
    for (int k = 0; k < n; k++) send_tick($urandom_range(0, 99) < restart_pct);
  endtask

  initial begin
    logic [lfo_pkg::CfgW-1:0] per;
    int                       sel;
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = lfo_pkg::RegWaveform;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    restart_i  = 1'b0;
    cycles     = 0;
    phases     = 0;
    no_gaps    = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset defaults: cosine over 256 ticks, restart in the middle
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    // Triangle with unused bits set, period of one, period zero
    run_phase(13'h1FFF, 13'd1, 2, 50);
    run_phase(13'h1FFF, 13'd0, 2, 0);
    // Cosine with only upper bits set, period of one
    run_phase(13'h1FFE, 13'd1, 2, 0);
    // Saturated period, then a shortened period wraps the stored position
    run_phase(13'd1, 13'h1FFF, 4, 0);
    run_phase(13'd1, 13'd2, 3, 0);
    run_phase(13'd0, 13'd3, 4, 0);
    run_phase(13'd0, 13'd4096, 3, 50);

    // Random phases: mostly short periods, some extremes
    for (int ph = 0; ph < 16; ph++) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0:       per = 13'd0;
        1:       per = 13'd1;
        2:       per = 13'd4096;
        3:       per = 13'($urandom_range(4097, 8191));
        4:       per = 13'($urandom_range(65, 4095));
        default: per = 13'($urandom_range(2, 64));
      endcase
      no_gaps = ($urandom_range(0, 3) == 0);
      run_phase(13'($urandom), per, 50, 10);
    end
    no_gaps = 1'b0;

    drain();
    repeat (600) @(posedge clk_i);
    $display("checked %0d ticks over %0d register settings,", checked, phases);
    $display("both shapes, periods from zero to saturated, random restarts and stalls");
    if (fail_cnt == 0 && pending == 0) begin
      $display("lfo_wave_generator: match");
    end else begin
      $display("lfo_wave_generator: mismatch");
    end
    $finish;
  end

endmodule
